@@ rtl/pcsg_pkg.sv @@
package pcsg_pkg;

    localparam int PITCH_W    = 15;
    localparam int CONF_W     = 16;
    localparam int BLK_W      = 13;
    localparam int SR_W       = 18;
    localparam int TEMPO_W    = 17;
    localparam int CLASS_W    = 4;
    localparam int OFFSET_W   = 5;
    localparam int DIVIDEND_W = 28;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CONF_W-1:0] CONF_LOW_MAX = 16'd13107;
    localparam logic [9:0]        WINDOW_NUM   = 10'd750;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO       = 1'b1;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [TEMPO_W-1:0]    divisor;
    } pcsg_div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } pcsg_div_rsp_t;

    // round half up to a whole note, then mod 12 via reciprocal multiply
    function automatic logic [CLASS_W-1:0] pitch_class(input logic [PITCH_W-1:0] pitch);
        logic [PITCH_W:0] rounded;
        logic [7:0]       note;
        logic [18:0]      prod;
        logic [3:0]       q;
        logic [7:0]       r;
        rounded = {1'b0, pitch} + 16'd128;
        note    = rounded[15:8];
        prod    = {11'd0, note} * 19'd171;
        q       = prod[14:11];
        r       = note - ({4'd0, q} * 8'd12);
        return r[CLASS_W-1:0];
    endfunction

endpackage

@@ rtl/pcsg_item_if.sv @@
interface pcsg_item_if
    import pcsg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PITCH_W-1:0] pitch_midi;
    logic [CONF_W-1:0]  confidence;
    logic [BLK_W-1:0]   block_samples;
    logic               is_silent;

    modport source (output valid, pitch_midi, confidence, block_samples, is_silent,
                    input ready);
    modport sink   (input valid, pitch_midi, confidence, block_samples, is_silent,
                    output ready);
endinterface

@@ rtl/pcsg_result_if.sv @@
interface pcsg_result_if
    import pcsg_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       note_valid;
    logic signed [OFFSET_W-1:0] note_offset;
    logic                       last_valid;
    logic signed [OFFSET_W-1:0] last_offset;

    modport source (output valid, note_valid, note_offset, last_valid, last_offset,
                    input ready);
    modport sink   (input valid, note_valid, note_offset, last_valid, last_offset,
                    output ready);
endinterface

@@ rtl/pcsg_cfg_if.sv @@
interface pcsg_cfg_if
    import pcsg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SR_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/pcsg_div.sv @@
module pcsg_div
    import pcsg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pcsg_div_req_t req,
    output pcsg_div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TEMPO_W-1:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [TEMPO_W-1:0]    dsr_reg, dsr_next;
    logic [TEMPO_W:0]      trial;
    logic [TEMPO_W:0]      diff;
    logic                  fits;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            rem_next  = fits ? diff[TEMPO_W-1:0] : trial[TEMPO_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg != LAST_STEP |=> busy_reg)
        else $error("divider stopped early");
    a_start_restarts_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && req.start |=> busy_reg && step_reg == '0)
        else $error("divider did not start cleanly");

endmodule

@@ rtl/pitch_class_stability_gate_unit.sv @@
// Pitch class stability gate. Each transfer on item gives exactly one transfer on
// result. The unit takes one item at a time. A confident, non-silent item with a
// nonzero tempo goes from S_IDLE to S_DIV, where the 28-step bit-serial divider
// forms the window 750*sample_rate/tempo; the quotient is latched into the window
// register, then S_EMIT loads the result, and the unit returns to S_IDLE to take the
// next item. A silent or low-confidence item, or one with tempo zero, goes straight
// from S_IDLE to S_EMIT, which loads its result. The result register frees item
// ready while a finished result waits; a further result waits until that one is
// taken. cfg is always ready; write it only when idle.
module pitch_class_stability_gate_unit
    import pcsg_pkg::*;
#(
    parameter int ROOT_CLASS = 0,
    parameter int COUNT_BITS = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    pcsg_cfg_if.sink      cfg,
    pcsg_item_if.sink     item,
    pcsg_result_if.source result
);

    localparam int CMP_W = (COUNT_BITS > DIVIDEND_W) ? COUNT_BITS : DIVIDEND_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [OFFSET_W-1:0]   ROOT_OFF  = OFFSET_W'(ROOT_CLASS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SR_W-1:0]       sample_rate_reg;
    logic [TEMPO_W-1:0]    tempo_reg;
    logic                  hold_reg, hold_next;
    logic [CLASS_W-1:0]    cand_reg, cand_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  elig_reg, elig_next;
    logic [DIVIDEND_W-1:0] window_reg, window_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  note_reg, note_next;
    logic [OFFSET_W-1:0]   note_off_reg, note_off_next;
    logic                  last_reg, last_next;
    logic [OFFSET_W-1:0]   last_off_reg, last_off_next;

    pcsg_div_req_t         div_req;
    pcsg_div_rsp_t         div_rsp;

    logic                  item_xfer;
    logic                  confident;
    logic [CLASS_W-1:0]    cls;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS:0]   blk_ext;
    logic                  out_free;
    logic                  note_hit;
    logic [OFFSET_W-1:0]   cand_off;

    assign item_xfer = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign confident = item.confidence > CONF_LOW_MAX;
    assign cls       = pitch_class(item.pitch_midi);
    assign blk_ext   = (COUNT_BITS + 1)'(item.block_samples);
    assign sum       = {1'b0, count_reg} + blk_ext;
    assign out_free  = !out_valid_reg || result.ready;
    assign note_hit  = elig_reg && (CMP_W'(count_reg) >= CMP_W'(window_reg));
    assign cand_off  = {1'b0, cand_reg} - ROOT_OFF;

    assign div_req.start    = item_xfer && !item.is_silent && confident && (tempo_reg != '0);
    assign div_req.dividend = {18'd0, WINDOW_NUM} * {10'd0, sample_rate_reg};
    assign div_req.divisor  = tempo_reg;

    pcsg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= 18'd48000;
            tempo_reg       <= 17'd12000;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SAMPLE_RATE: sample_rate_reg <= cfg.data;
                CFG_TEMPO:       tempo_reg       <= cfg.data[TEMPO_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hold_next      = hold_reg;
        cand_next      = cand_reg;
        count_next     = count_reg;
        elig_next      = elig_reg;
        window_next    = window_reg;
        out_valid_next = out_valid_reg && !result.ready;
        note_next      = note_reg;
        note_off_next  = note_off_reg;
        last_next      = last_reg;
        last_off_next  = last_off_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    elig_next   = 1'b0;
                    window_next = DIVIDEND_W'(sample_rate_reg >> 4);
                    state_next  = S_EMIT;
                    if (item.is_silent)
                    begin
                        hold_next  = 1'b0;
                        count_next = '0;
                    end
                    else if (!confident)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        hold_next = 1'b1;
                        elig_next = 1'b1;
                        cand_next = cls;
                        if (cls == cand_reg)
                            count_next = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
                        else
                            count_next = blk_ext[COUNT_BITS-1:0];
                        if (tempo_reg != '0)
                            state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    window_next = div_rsp.quotient;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    note_next      = note_hit;
                    note_off_next  = note_hit ? cand_off : '0;
                    last_next      = hold_reg;
                    last_off_next  = hold_reg ? cand_off : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hold_reg      <= 1'b0;
            cand_reg      <= '0;
            count_reg     <= '0;
            elig_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hold_reg      <= hold_next;
            cand_reg      <= cand_next;
            count_reg     <= count_next;
            elig_reg      <= elig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg   <= window_next;
        note_reg     <= note_next;
        note_off_reg <= note_off_next;
        last_reg     <= last_next;
        last_off_reg <= last_off_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.note_valid  = note_reg;
    assign result.note_offset = note_off_reg;
    assign result.last_valid  = last_reg;
    assign result.last_offset = last_off_reg;

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> state_reg != S_IDLE)
        else $error("item taken without starting work");
    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_rsp.busy || div_rsp.done)
        else $error("waiting on an idle divider");
    a_note_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && note_reg |-> last_reg && note_off_reg == last_off_reg)
        else $error("note reported without matching held class");
    a_quiet_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> !note_reg && last_off_reg == '0)
        else $error("offset reported without a held pitch");

endmodule

@@ sim/pitch_class_stability_gate_unit_test.sv @@
`timescale 1ns / 1ps

module pitch_class_stability_gate_unit_test;
    import pcsg_pkg::*;

    localparam int ROOT_CLASS     = 0;
    localparam int COUNT_BITS     = 24;
    localparam int SR_RESET       = 48000;
    localparam int TEMPO_RESET    = 12000;
    localparam int SR_LOW         = 8000;
    localparam int SR_HIGH        = 192000;
    localparam int TEMPO_HIGH     = 100000;
    localparam int CONF_MAX       = 65535;
    localparam int PITCH_MAX      = 32767;
    localparam int BLK_MAX        = 8191;
    localparam int BLK_HIGH       = 4096;
    localparam int DRAIN_CYCLES   = 64;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RUN_ITEMS      = 40;
    localparam int PHASE_ITEMS    = 45;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch_midi;
        logic [CONF_W-1:0]  confidence;
        logic [BLK_W-1:0]   block_samples;
        logic               is_silent;
    } pitch_item_t;

    typedef struct packed {
        logic                       note_valid;
        logic signed [OFFSET_W-1:0] note_offset;
        logic                       last_valid;
        logic signed [OFFSET_W-1:0] last_offset;
    } gate_result_t;

    logic clk;
    logic rst_n;

    pcsg_cfg_if    cfg();
    pcsg_item_if   item();
    pcsg_result_if result();

    pitch_class_stability_gate_unit #(
        .ROOT_CLASS(ROOT_CLASS),
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .item(item),
        .result(result)
    );

    // predicted gate state
    logic [SR_W-1:0]       gate_sample_rate;
    logic [TEMPO_W-1:0]    gate_tempo;
    logic                  gate_hold;
    logic [CLASS_W-1:0]    gate_class;
    logic [COUNT_BITS-1:0] gate_count;

    gate_result_t expected_notes[$];
    int           error_count;

    rx_mode_t rx_mode;
    bit       tx_gaps_on;
    int       tx_burst_left;
    logic     holdoff_req;
    logic     holdoff_active;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [OFFSET_W-1:0] class_offset(input logic [CLASS_W-1:0] cls);
        int d;
        d = int'(cls) - ROOT_CLASS;
        return d[OFFSET_W-1:0];
    endfunction

    function automatic gate_result_t predict_gate(input pitch_item_t it);
        gate_result_t       r;
        logic [CLASS_W-1:0] cls;
        longint unsigned    window;
        longint unsigned    sum;
        longint unsigned    count_max;
        logic               note;
        note      = 1'b0;
        cls       = '0;
        count_max = (64'd1 << COUNT_BITS) - 64'd1;
        if (it.is_silent)
        begin
            gate_hold  = 1'b0;
            gate_count = '0;
        end
        else if (it.confidence <= CONF_LOW_MAX)
        begin
            gate_count = '0;
        end
        else
        begin
            gate_hold = 1'b1;
            cls = CLASS_W'(((int'(it.pitch_midi) + 128) >> 8) % 12);
            if (cls == gate_class)
                sum = 64'(gate_count) + 64'(it.block_samples);
            else
            begin
                sum        = 64'(it.block_samples);
                gate_class = cls;
            end
            if (sum > count_max)
                sum = count_max;
            gate_count = sum[COUNT_BITS-1:0];
            if (gate_tempo != 0)
                window = (64'd750 * 64'(gate_sample_rate)) / 64'(gate_tempo);
            else
                window = 64'(gate_sample_rate) / 64'd16;
            note = 64'(gate_count) >= window;
        end
        r.note_valid  = note;
        r.note_offset = note ? class_offset(cls) : '0;
        r.last_valid  = gate_hold;
        r.last_offset = gate_hold ? class_offset(gate_class) : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        gate_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_notes.size() == 0)
            begin
                $error("result transfer with no item pending");
                error_count++;
            end
            else
            begin
                want = expected_notes.pop_front();
                check_field("note_valid", want.note_valid, result.note_valid);
                check_field("note_offset", want.note_offset, result.note_offset);
                check_field("last_valid", want.last_valid, result.last_valid);
                check_field("last_offset", want.last_offset, result.last_offset);
            end
        end
        if (rst_n && item.valid && item.ready)
            expected_notes.push_back(predict_gate({item.pitch_midi, item.confidence,
                                                   item.block_samples, item.is_silent}));
        if (rst_n && cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_SAMPLE_RATE)
                gate_sample_rate = cfg.data;
            else
                gate_tempo = cfg.data[TEMPO_W-1:0];
        end
    end

    initial
    begin : rx_ready_driver
        int unsigned phase;
        phase        = 0;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (holdoff_active)
                result.ready <= 1'b0;
            else
                case (rx_mode)
                    RX_FREE:   result.ready <= 1'b1;
                    RX_RANDOM: result.ready <= ($urandom_range(0, 3) != 0);
                    default:   result.ready <= ((phase % 7) < 4);
                endcase
        end
    end

    initial
    begin : rx_holdoff
        holdoff_active = 1'b0;
        forever
        begin
            wait (holdoff_req);
            @(posedge clk);
            holdoff_active = 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clk);
            holdoff_active = 1'b0;
            holdoff_req    = 1'b0;
        end
    end

    function automatic pitch_item_t make_item(input int pitch, input int conf,
                                              input int blk, input bit silent);
        pitch_item_t it;
        it.pitch_midi    = pitch[PITCH_W-1:0];
        it.confidence    = conf[CONF_W-1:0];
        it.block_samples = blk[BLK_W-1:0];
        it.is_silent     = silent;
        return it;
    endfunction

    function automatic int pitch_for_class(input int cls);
        int note;
        int lo;
        int hi;
        note = cls + 12 * $urandom_range(0, (128 - cls) / 12);
        lo   = note * 256 - 128;
        hi   = note * 256 + 127;
        if (lo < 0)
            lo = 0;
        if (hi > PITCH_MAX)
            hi = PITCH_MAX;
        return $urandom_range(lo, hi);
    endfunction

    function automatic int rand_block();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, BLK_MAX);
            1:       return $urandom_range(1, 16);
            default: return $urandom_range(1, BLK_HIGH);
        endcase
    endfunction

    task automatic send_item(input pitch_item_t it);
        if (tx_gaps_on && tx_burst_left <= 0)
        begin
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4))
            begin
                @(negedge clk);
                item.valid <= 1'b0;
            end
            tx_burst_left = $urandom_range(1, 12);
        end
        tx_burst_left--;
        @(negedge clk);
        item.valid         <= 1'b1;
        item.pitch_midi    <= it.pitch_midi;
        item.confidence    <= it.confidence;
        item.block_samples <= it.block_samples;
        item.is_silent     <= it.is_silent;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    task automatic drain(input int extra);
        int waited;
        @(negedge clk);
        item.valid <= 1'b0;
        waited = 0;
        while (expected_notes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_notes.size() != 0)
        begin
            $error("%0d results never arrived", expected_notes.size());
            error_count++;
            expected_notes.delete();
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[SR_W-1:0];
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_window(input int sr, input int tempo);
        drain(DRAIN_CYCLES);
        write_reg(CFG_SAMPLE_RATE, sr);
        write_reg(CFG_TEMPO, tempo);
    endtask

    // reset config: window = 3000 samples
    task automatic test_directed_defaults();
        int cls;
        rx_mode    = RX_FREE;
        tx_gaps_on = 1'b0;
        send_item(make_item(0, 0, 0, 1'b1));
        send_item(make_item(PITCH_MAX, CONF_MAX, BLK_MAX, 1'b1));
        send_item(make_item(0, CONF_MAX, 1, 1'b0));
        send_item(make_item(127, 13108, 1, 1'b0));
        send_item(make_item(128, CONF_MAX, BLK_HIGH, 1'b0));
        send_item(make_item(1000, 13107, BLK_HIGH, 1'b0));
        send_item(make_item(PITCH_MAX, CONF_MAX, 0, 1'b0));
        send_item(make_item(PITCH_MAX, CONF_MAX, 2999, 1'b0));
        send_item(make_item(PITCH_MAX, CONF_MAX, 1, 1'b0));
        send_item(make_item(PITCH_MAX, CONF_MAX, BLK_MAX, 1'b0));
        send_item(make_item(PITCH_MAX, 0, BLK_MAX, 1'b0));
        send_item(make_item(PITCH_MAX, CONF_MAX, 1, 1'b0));
        send_item(make_item(0, CONF_MAX, BLK_MAX, 1'b1));
        send_item(make_item(PITCH_MAX, CONF_MAX, BLK_HIGH, 1'b0));
        for (cls = 0; cls < 12; cls++)
            send_item(make_item(pitch_for_class(cls), $urandom_range(13108, CONF_MAX),
                                BLK_HIGH, 1'b0));
    endtask

    task automatic test_config_extremes();
        int sr_list[7]    = '{SR_LOW, SR_HIGH, SR_LOW, SR_HIGH, 1, 262143, SR_RESET};
        int tempo_list[7] = '{TEMPO_HIGH, 1, 0, 0, TEMPO_HIGH, 131071, TEMPO_RESET};
        int k;
        int n;
        int cls;
        for (k = 0; k < 7; k++)
        begin
            set_window(sr_list[k], tempo_list[k]);
            cls = $urandom_range(0, 11);
            for (n = 0; n < 4; n++)
                send_item(make_item(pitch_for_class(cls), CONF_MAX, rand_block(), 1'b0));
        end
    endtask

    // window of 240000 samples; the counter climbs past it in one long run
    task automatic test_long_count();
        int n;
        set_window(SR_LOW, 25);
        for (n = 0; n < RUN_ITEMS; n++)
            send_item(make_item(pitch_for_class(5), CONF_MAX, BLK_MAX, 1'b0));
        send_item(make_item(pitch_for_class(5), 0, BLK_MAX, 1'b0));
        send_item(make_item(pitch_for_class(5), CONF_MAX, BLK_MAX, 1'b0));
    endtask

    task automatic test_backpressure();
        int n;
        set_window(SR_LOW, TEMPO_HIGH);
        rx_mode     = RX_FREE;
        tx_gaps_on  = 1'b0;
        holdoff_req = 1'b1;
        for (n = 0; n < 24; n++)
            send_item(make_item(pitch_for_class(n % 3), CONF_MAX, rand_block(), n == 10));
    endtask

    task automatic test_random_traffic();
        int phase;
        int sent;
        int run;
        int cls;
        int n;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_window(SR_LOW, TEMPO_HIGH);
                1:       set_window(SR_HIGH, 0);
                2:       set_window($urandom_range(SR_LOW, SR_HIGH), 0);
                default: set_window($urandom_range(SR_LOW, SR_HIGH),
                                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, TEMPO_HIGH)
                                                                : $urandom_range(6000, TEMPO_HIGH));
            endcase
            rx_mode       = rx_mode_t'($urandom_range(0, 2));
            tx_gaps_on    = (phase != 1);
            tx_burst_left = 0;
            sent          = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    cls = $urandom_range(0, 11);
                    run = $urandom_range(1, 8);
                    for (n = 0; n < run; n++)
                        send_item(make_item(pitch_for_class(cls),
                                            $urandom_range(13108, CONF_MAX), rand_block(), 1'b0));
                    sent += run;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: send_item(make_item($urandom_range(0, PITCH_MAX),
                                               $urandom_range(0, CONF_MAX),
                                               $urandom_range(0, BLK_MAX), 1'b1));
                        1: send_item(make_item($urandom_range(0, PITCH_MAX),
                                               $urandom_range(0, 13107), rand_block(), 1'b0));
                        default: send_item(make_item($urandom_range(0, PITCH_MAX),
                                                     $urandom_range(0, CONF_MAX),
                                                     rand_block(), 1'b0));
                    endcase
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        error_count        = 0;
        rx_mode            = RX_FREE;
        tx_gaps_on         = 1'b0;
        tx_burst_left      = 0;
        holdoff_req        = 1'b0;
        rst_n              = 1'b0;
        item.valid         = 1'b0;
        item.pitch_midi    = '0;
        item.confidence    = '0;
        item.block_samples = '0;
        item.is_silent     = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = CFG_SAMPLE_RATE;
        cfg.data           = '0;
        gate_sample_rate   = SR_W'(SR_RESET);
        gate_tempo         = TEMPO_W'(TEMPO_RESET);
        gate_hold          = 1'b0;
        gate_class         = '0;
        gate_count         = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_defaults();
        test_config_extremes();
        test_long_count();
        test_backpressure();
        test_random_traffic();
        drain(DRAIN_CYCLES);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
